// ===== src/lamp_fade_ramp_controller_top_assert.svh =====
// Assertion macros for the lamp fade ramp controller.
`ifndef LAMP_FADE_RAMP_CONTROLLER_TOP_ASSERT_SVH
`define LAMP_FADE_RAMP_CONTROLLER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on aclk outside reset
`define LFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on aclk outside reset
`define LFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFR_ASSERT_NOW(label, ante, cons, msg)
`define LFR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/lfr_pkg.sv =====
// Shared types and constants for the lamp fade ramp controller.
`default_nettype none
package lfr_pkg;

    // Command codes carried on s_tuser
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    localparam logic [7:0] FULL_SCALE       = 8'd255;
    localparam logic [7:0] FADE_PERIODS_RST = 8'd1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_IN   = 2'd1,
        MODE_OUT  = 2'd2
    } lfr_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } lfr_state_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } lfr_div_stat_t;

endpackage
`default_nettype wire

// ===== src/lfr_div.sv =====
// Restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit a cycle.
`default_nettype none
module lfr_div (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [15:0]            dividend,
    input  wire logic [7:0]             divisor,
    output lfr_pkg::lfr_div_stat_t      stat,
    output logic      [15:0]            quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dsr_reg, dsr_next;

    logic [8:0]  trial;
    logic [8:0]  diff;
    logic        fits;

    // one trial subtraction per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[15]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = 4'd0;
            quo_next  = dividend;
            rem_next  = 8'd0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[7:0] : trial[7:0];
            quo_next  = {quo_reg[14:0], fits};
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
`default_nettype wire

// ===== src/lamp_fade_ramp_controller_top.sv =====
// Top level of the lamp fade ramp controller: sequencer, lamp state and output register.
//
//  Channel  | Ports                              | Word contents (low bit first)
//  ---------+------------------------------------+-----------------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser  | tdata: level[7:0]; tuser: command[1:0]
//  result   | m_tvalid m_tready m_tdata          | compare_value[7:0], fade_mode_now[9:8]
//  config   | cfg_wr_en cfg_wr_data              | fade_periods[7:0]
//
// On and off words and ignored ticks are handled in the idle state alone. An idle tick
// also passes the done state. A tick during a fade passes the 8x8 multiply state, the
// shared bit-serial divider (16 steps, then its done strobe) and the done state.
// Reset (aresetn low, synchronous) clears lamp state and sets fade_periods to 1.
// A finished result waits in the output register; a new word is taken meanwhile.
// While that register still holds an unaccepted word, the next result stalls the sequencer.
`default_nettype none
`include "lamp_fade_ramp_controller_top_assert.svh"
module lamp_fade_ramp_controller_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // fade_periods
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] level
    input  wire logic [1:0]  s_tuser,       // [1:0] command
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata        // [7:0] compare_value, [9:8] fade_mode_now
);

    lfr_pkg::lfr_state_t state_reg, state_next;
    lfr_pkg::lfr_mode_t  mode_reg, mode_next;
    logic        lamp_on_reg, lamp_on_next;
    logic        tick_en_reg, tick_en_next;
    logic [7:0]  elapsed_reg, elapsed_next;
    logic [7:0]  fade_periods_reg;

    logic [7:0]  count_reg, count_next;
    logic [7:0]  level_reg, level_next;
    logic [7:0]  divisor_reg, divisor_next;
    logic [7:0]  cmp_reg, cmp_next;
    lfr_pkg::lfr_mode_t res_mode_reg, res_mode_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_cmp_reg, out_cmp_next;
    lfr_pkg::lfr_mode_t out_mode_reg, out_mode_next;

    logic        accept;
    logic [7:0]  p_eff;
    logic [7:0]  mirror_now;
    logic [7:0]  elapsed_inc;
    logic [7:0]  mirror_inc;
    logic        fade_ends;

    logic        div_start;
    logic [15:0] product;
    logic [15:0] quotient;
    lfr_pkg::lfr_div_stat_t div_stat;

    assign accept = s_tvalid && s_tready;

    // effective period count and mirrored counters
    always_comb begin
        p_eff       = (fade_periods_reg == 8'd0) ? 8'd1 : fade_periods_reg;
        mirror_now  = (p_eff > elapsed_reg) ? (p_eff - elapsed_reg) : 8'd0;
        elapsed_inc = (elapsed_reg == 8'd255) ? 8'd255 : (elapsed_reg + 8'd1);
        mirror_inc  = (p_eff > elapsed_inc) ? (p_eff - elapsed_inc) : 8'd0;
        fade_ends   = (elapsed_inc >= p_eff);
    end

    // shared divider works on the registered product
    assign div_start = (state_reg == lfr_pkg::ST_MUL);
    assign product   = {8'd0, count_reg} * {8'd0, level_reg};

    lfr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (divisor_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // sequencer and lamp state
    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        lamp_on_next  = lamp_on_reg;
        tick_en_next  = tick_en_reg;
        elapsed_next  = elapsed_reg;
        count_next    = count_reg;
        level_next    = level_reg;
        divisor_next  = divisor_reg;
        cmp_next      = cmp_reg;
        res_mode_next = res_mode_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cmp_next  = out_cmp_reg;
        out_mode_next = out_mode_reg;
        s_tready      = 1'b0;

        unique case (state_reg)
            lfr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    priority if (s_tuser == lfr_pkg::CMD_ON) begin
                        if (!lamp_on_reg) begin
                            lamp_on_next = 1'b1;
                            if (mode_reg == lfr_pkg::MODE_OUT) begin
                                elapsed_next = mirror_now;
                            end else if (mode_reg != lfr_pkg::MODE_IN) begin
                                elapsed_next = 8'd0;
                            end
                            mode_next    = lfr_pkg::MODE_IN;
                            tick_en_next = 1'b1;
                        end
                    end else if (s_tuser == lfr_pkg::CMD_OFF) begin
                        if (lamp_on_reg) begin
                            lamp_on_next = 1'b0;
                            elapsed_next = (mode_reg == lfr_pkg::MODE_IN) ? mirror_now : 8'd0;
                            mode_next    = lfr_pkg::MODE_OUT;
                        end
                    end else if (s_tuser == lfr_pkg::CMD_TICK && tick_en_reg) begin
                        if (mode_reg == lfr_pkg::MODE_IN || mode_reg == lfr_pkg::MODE_OUT) begin
                            elapsed_next = elapsed_inc;
                            count_next   = (mode_reg == lfr_pkg::MODE_IN) ? elapsed_inc
                                                                          : mirror_inc;
                            level_next   = s_tdata;
                            divisor_next = p_eff;
                            if (fade_ends) begin
                                if (mode_reg == lfr_pkg::MODE_OUT) begin
                                    tick_en_next = 1'b0;
                                end
                                mode_next = lfr_pkg::MODE_IDLE;
                            end
                            res_mode_next = fade_ends ? lfr_pkg::MODE_IDLE : mode_reg;
                            state_next    = lfr_pkg::ST_MUL;
                        end else begin
                            mode_next     = lfr_pkg::MODE_IDLE;
                            cmp_next      = lfr_pkg::FULL_SCALE - s_tdata;
                            res_mode_next = lfr_pkg::MODE_IDLE;
                            state_next    = lfr_pkg::ST_DONE;
                        end
                    end else begin
                        // unused command or tick while disabled: dropped
                    end
                end
            end
            lfr_pkg::ST_MUL: begin
                state_next = lfr_pkg::ST_DIV;
            end
            lfr_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    // saturate duty to full scale
                    cmp_next   = (quotient[15:8] != 8'd0) ? 8'd0
                                 : (lfr_pkg::FULL_SCALE - quotient[7:0]);
                    state_next = lfr_pkg::ST_DONE;
                end
            end
            lfr_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_cmp_next   = cmp_reg;
                    out_mode_next  = res_mode_reg;
                    state_next     = lfr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfr_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= lfr_pkg::ST_IDLE;
            mode_reg         <= lfr_pkg::MODE_IDLE;
            lamp_on_reg      <= 1'b0;
            tick_en_reg      <= 1'b0;
            elapsed_reg      <= 8'd0;
            fade_periods_reg <= lfr_pkg::FADE_PERIODS_RST;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            lamp_on_reg   <= lamp_on_next;
            tick_en_reg   <= tick_en_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                fade_periods_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        count_reg    <= count_next;
        level_reg    <= level_next;
        divisor_reg  <= divisor_next;
        cmp_reg      <= cmp_next;
        res_mode_reg <= res_mode_next;
        out_cmp_reg  <= out_cmp_next;
        out_mode_reg <= out_mode_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_mode_reg, out_cmp_reg};

    // checks
    `LFR_ASSERT_NOW(a_on_has_ticks, lamp_on_reg, tick_en_reg, "lamp on with ticks disabled")
    `LFR_ASSERT_NOW(a_fade_out_off, mode_reg == lfr_pkg::MODE_OUT, !lamp_on_reg, "on in fade out")
    `LFR_ASSERT_NOW(a_div_done_state, div_stat.done, state_reg == lfr_pkg::ST_DIV, "stray div done")
    `LFR_ASSERT_NEXT(a_mul_follows, state_reg == lfr_pkg::ST_MUL, div_stat.busy, "divider not started")

endmodule
`default_nettype wire
